### rtl/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

    localparam int ACC_W  = 60;
    localparam int MANT_W = 61;
    localparam int FRAC_W = 5;

    localparam logic [63:0] MANT_MAX = 64'd999999999999999999;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] TYPE_TEXT    = 2'd0;
    localparam logic [1:0] TYPE_INTEGER = 2'd1;
    localparam logic [1:0] TYPE_DECIMAL = 2'd2;

    // Number view of the field so far, as seen by the end item
    typedef struct packed {
        logic                     numeric;
        logic                     point;
        logic signed [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0]        places;
    } num_view_t;

endpackage

### rtl/cft_number.sv
`timescale 1ns / 1ps

module cft_number
    import cft_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS = 18
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       clear,
    input  logic [7:0] char_in,
    output num_view_t  view
);

    logic              numeric_reg, numeric_next;
    logic              point_reg, point_next;
    logic              started_reg, started_next;
    logic              ended_reg, ended_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;

    logic        is_digit;
    logic        is_letter;
    logic [63:0] acc_x10;
    logic [63:0] acc_sum;

    assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_letter = ((char_in >= 8'h41) && (char_in <= 8'h5A)) ||
                       ((char_in >= 8'h61) && (char_in <= 8'h7A));

    // times ten as two shifted adds, then the new digit
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum = acc_x10 + {60'd0, 4'(char_in - CH_ZERO)};

    always_comb begin
        numeric_next = numeric_reg;
        point_next   = point_reg;
        started_next = started_reg;
        ended_next   = ended_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        frac_next    = frac_reg;
        if (clear) begin
            numeric_next = 1'b1;
            point_next   = 1'b0;
            started_next = 1'b0;
            ended_next   = 1'b0;
            neg_next     = 1'b0;
            acc_next     = '0;
            frac_next    = '0;
        end else if (step) begin
            if (is_letter) begin
                numeric_next = 1'b0;
            end
            if ((char_in == CH_MINUS) && numeric_next && !started_reg) begin
                neg_next = !neg_reg;
            end
            if ((char_in == CH_POINT) && numeric_next) begin
                if (!point_reg) begin
                    point_next = 1'b1;
                end else begin
                    numeric_next = 1'b0;
                    ended_next   = 1'b1;
                end
            end
            if (is_digit && numeric_next && ended_next) begin
                numeric_next = 1'b0;
            end else if (is_digit && numeric_next) begin
                started_next = 1'b1;
                if (!point_next || (frac_reg < FRAC_W'(MAX_FRACTION_DIGITS))) begin
                    acc_next = (acc_sum > MANT_MAX) ? MANT_MAX[ACC_W-1:0]
                                                    : acc_sum[ACC_W-1:0];
                    if (point_next) begin
                        frac_next = frac_reg + 1'b1;
                    end
                end
            end else if (((char_in == CH_QUOTE) || (char_in == CH_SPACE)) &&
                         numeric_next && started_next && !ended_next) begin
                ended_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            numeric_reg <= 1'b1;
            point_reg   <= 1'b0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            frac_reg    <= '0;
        end else begin
            numeric_reg <= numeric_next;
            point_reg   <= point_next;
            started_reg <= started_next;
            ended_reg   <= ended_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
        end
    end

    always_comb begin
        view.numeric  = numeric_reg;
        view.point    = point_reg;
        view.mantissa = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        view.places   = frac_reg;
    end

endmodule

### rtl/csv_field_tokenizer_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_byte_in: one CSV byte
// m_        out        m_valid/m_ready    text byte or end-of-field item
//
// One byte is taken per cycle while s_ready is high; each byte's item (if any)
// appears in the output register on the next cycle. The limit is the
// state update (times-ten add and saturate compare on the 60-bit accumulator).
// Reset (aresetn low, synchronous) returns to the header row with an empty field.
// While the output register holds an item that is not taken, s_ready stays low.

module csv_field_tokenizer_top
    import cft_pkg::*;
#(
    parameter int MAX_HELD_SPACES     = 255,
    parameter int MAX_FRACTION_DIGITS = 18
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_byte_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_end_of_field,
    output logic [7:0]               m_text_byte,
    output logic [7:0]               m_spaces_before,
    output logic                     m_end_of_row,
    output logic                     m_header_row,
    output logic [1:0]               m_field_type,
    output logic signed [MANT_W-1:0] m_mantissa,
    output logic [FRAC_W-1:0]        m_decimal_places
);

    localparam int HELD_W = $clog2(MAX_HELD_SPACES + 1);

    logic              header_reg, header_next;
    logic              quotes_reg, quotes_next;
    logic              pending_reg, pending_next;
    logic              quoted_reg, quoted_next;
    logic              started_reg, started_next;
    logic [HELD_W-1:0] held_reg, held_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     eof_reg;
    logic [7:0]               text_reg;
    logic [7:0]               spaces_reg;
    logic                     eor_reg;
    logic                     hdr_reg;
    logic [1:0]               type_reg;
    logic signed [MANT_W-1:0] mant_reg;
    logic [FRAC_W-1:0]        places_reg;

    logic              accept;
    logic              do_text;
    logic              do_end;
    logic              row_end;
    logic [HELD_W-1:0] sp_raw;
    logic [16:0]       sp_wide;
    logic [7:0]        sp_sat;
    logic [1:0]        type_out;
    logic signed [MANT_W-1:0] mant_out;
    logic [FRAC_W-1:0] places_out;
    num_view_t         num;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cft_number #(
        .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
    ) u_number (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept && header_reg == 1'b0),
        .clear   (accept && do_end),
        .char_in (s_byte_in),
        .view    (num)
    );

    always_comb begin
        header_next  = header_reg;
        quotes_next  = quotes_reg;
        pending_next = pending_reg;
        quoted_next  = quoted_reg;
        started_next = started_reg;
        held_next    = held_reg;
        do_text      = 1'b0;
        do_end       = 1'b0;
        row_end      = 1'b0;
        sp_raw       = '0;

        if (quotes_reg && pending_reg) begin
            // doubled quote gives a literal; anything else closes the quotes
            if (s_byte_in == CH_QUOTE) begin
                do_text = 1'b1;
            end
        end else if (quotes_reg) begin
            if (s_byte_in != CH_QUOTE) begin
                do_text = 1'b1;
            end
        end else if (s_byte_in == CH_COMMA) begin
            do_end = 1'b1;
        end else if (s_byte_in == CH_NEWLINE) begin
            do_end  = 1'b1;
            row_end = 1'b1;
        end else if (s_byte_in != CH_QUOTE && s_byte_in != CH_SPACE) begin
            do_text = 1'b1;
        end

        if (accept) begin
            if (quotes_reg && pending_reg) begin
                pending_next = 1'b0;
                if (s_byte_in != CH_QUOTE) begin
                    quotes_next = 1'b0;
                end
            end else if (quotes_reg) begin
                if (s_byte_in == CH_QUOTE) begin
                    pending_next = 1'b1;
                end
            end
            if (!quotes_reg || (pending_reg && s_byte_in != CH_QUOTE)) begin
                if (s_byte_in == CH_QUOTE) begin
                    quotes_next = 1'b1;
                    quoted_next = 1'b1;
                end else if (s_byte_in == CH_SPACE) begin
                    if (held_reg < HELD_W'(MAX_HELD_SPACES)) begin
                        held_next = held_reg + 1'b1;
                    end
                end
            end
        end

        // also covers the quote-closing byte, which falls through above
        if (quotes_reg && pending_reg && s_byte_in != CH_QUOTE) begin
            if (s_byte_in == CH_COMMA) begin
                do_end = 1'b1;
            end else if (s_byte_in == CH_NEWLINE) begin
                do_end  = 1'b1;
                row_end = 1'b1;
            end else if (s_byte_in != CH_SPACE) begin
                do_text = 1'b1;
            end
        end

        if (do_text) begin
            sp_raw = (started_reg || quoted_reg) ? held_reg : '0;
        end else if (do_end) begin
            sp_raw = quoted_reg ? held_reg : '0;
        end

        if (accept && do_text) begin
            held_next    = '0;
            started_next = 1'b1;
        end
        if (accept && do_end) begin
            quoted_next  = 1'b0;
            started_next = 1'b0;
            held_next    = '0;
            if (row_end) begin
                header_next = 1'b0;
            end
        end
    end

    assign sp_wide = 17'(sp_raw);
    assign sp_sat  = (sp_wide > 17'd255) ? 8'd255 : sp_wide[7:0];

    always_comb begin
        type_out   = TYPE_TEXT;
        mant_out   = '0;
        places_out = '0;
        if (!header_reg && num.numeric) begin
            mant_out = num.mantissa;
            if (num.point) begin
                type_out   = TYPE_DECIMAL;
                places_out = num.places;
            end else begin
                type_out = TYPE_INTEGER;
            end
        end
    end

    always_comb begin
        if (accept && (do_text || do_end)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= 1'b1;
            quotes_reg  <= 1'b0;
            pending_reg <= 1'b0;
            quoted_reg  <= 1'b0;
            started_reg <= 1'b0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            header_reg  <= header_next;
            quotes_reg  <= quotes_next;
            pending_reg <= pending_next;
            quoted_reg  <= quoted_next;
            started_reg <= started_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (do_text || do_end)) begin
            eof_reg    <= do_end;
            text_reg   <= do_text ? s_byte_in : 8'd0;
            spaces_reg <= sp_sat;
            eor_reg    <= row_end;
            hdr_reg    <= header_reg;
            type_reg   <= do_end ? type_out : TYPE_TEXT;
            mant_reg   <= do_end ? mant_out : '0;
            places_reg <= do_end ? places_out : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_end_of_field   = eof_reg;
    assign m_text_byte      = text_reg;
    assign m_spaces_before  = spaces_reg;
    assign m_end_of_row     = eor_reg;
    assign m_header_row     = hdr_reg;
    assign m_field_type     = type_reg;
    assign m_mantissa       = mant_reg;
    assign m_decimal_places = places_reg;

endmodule
